FILE: hw/rtl/quad_color_marker_scorer_assert.svh
// Assertion macros used by the merge stage of the quad colour marker scorer RTL
`ifndef QUAD_COLOR_MARKER_SCORER_ASSERT_SVH
`define QUAD_COLOR_MARKER_SCORER_ASSERT_SVH

// same-cycle implication
`define QCMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("qcms assertion failed");

// next-cycle implication
`define QCMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("qcms assertion failed");

`endif

FILE: hw/rtl/qcms_pkg.sv
// Shared types, constants and pair tables of the quad colour marker scorer
`default_nettype none

package qcms_pkg;

  localparam int unsigned HueW       = 8;
  localparam int unsigned SatW       = 8;
  localparam int unsigned SatSumW    = 10;
  localparam int unsigned GapW       = 8;
  localparam int unsigned ProdW      = 18;
  localparam int unsigned ScoreW     = 8;
  localparam int unsigned IdxW       = 2;
  localparam int unsigned NumCorners = 4;
  localparam int unsigned NumPairs   = 6;

  localparam logic [HueW-1:0]  HalfTurn       = 8'd90;
  localparam logic [HueW:0]    FullTurn       = 9'd180;
  localparam logic [HueW-1:0]  RedCutoffReset = 8'd140;
  localparam logic [ProdW-1:0] SatLimit       = 18'd25600;  // 256 * divisor of 100
  localparam logic [12:0]      RecipMul       = 13'd5243;   // ceil(2^19 / 100)
  localparam int unsigned      RecipShift     = 19;
  localparam int unsigned      QuotInW        = 15;
  localparam logic [ScoreW-1:0] ScoreMax      = 8'd255;

  typedef logic signed [GapW-1:0] gap_t;
  typedef logic [HueW-1:0]        hue_t;
  typedef logic [IdxW-1:0]        idx_t;

  typedef struct packed {
    logic                          valid;
    logic [NumPairs-1:0][GapW-1:0] gaps;
    logic [SatSumW-1:0]            sat_sum;
    logic [NumCorners-1:0][IdxW-1:0] ranks;
  } stage1_t;

  function automatic idx_t pair_hi(input int unsigned p);
    idx_t r;
    case (p)
      0:       r = 2'd1;
      1:       r = 2'd2;
      2:       r = 2'd2;
      3:       r = 2'd3;
      4:       r = 2'd3;
      5:       r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic idx_t pair_lo(input int unsigned p);
    idx_t r;
    case (p)
      0:       r = 2'd0;
      1:       r = 2'd0;
      2:       r = 2'd1;
      3:       r = 2'd0;
      4:       r = 2'd1;
      5:       r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/quad_color_marker_scorer.sv
// Top level of the quad colour marker scorer
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ------------------------------
//  command   hue_corner0..3_i, sat_corner0..3_i       start, busy (busy always low)
//  result    marker_score_o, red/yellow/green/blue_o  result_valid_o, one-cycle strobe
//  config    cfg_data_i (red wrap cutoff)             cfg_we_i
//
//  One item per clock; start is registered through s1_q, valid2_q and valid3_q to result_valid_o.
//  Stages: pair-gap and rank lanes, then min/product, then the reciprocal multiply.
//  Reset clears the pipeline valids and sets the cutoff to 140.
//  The receiver cannot stall; nothing in the block waits on it.
`default_nettype none

module quad_color_marker_scorer
  import qcms_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [HueW-1:0]   hue_corner0_i,
  input  wire logic [HueW-1:0]   hue_corner1_i,
  input  wire logic [HueW-1:0]   hue_corner2_i,
  input  wire logic [HueW-1:0]   hue_corner3_i,
  input  wire logic [SatW-1:0]   sat_corner0_i,
  input  wire logic [SatW-1:0]   sat_corner1_i,
  input  wire logic [SatW-1:0]   sat_corner2_i,
  input  wire logic [SatW-1:0]   sat_corner3_i,
  input  wire logic              cfg_we_i,
  input  wire logic [HueW-1:0]   cfg_data_i,
  output logic                   result_valid_o,
  output logic [ScoreW-1:0]      marker_score_o,
  output idx_t                   red_corner_o,
  output idx_t                   yellow_corner_o,
  output idx_t                   green_corner_o,
  output idx_t                   blue_corner_o
);

  hue_t                            hues [NumCorners];
  logic [NumCorners-1:0][HueW-1:0] keys;
  gap_t                            gaps [NumPairs];
  idx_t                            ranks [NumCorners];
  logic [SatSumW-1:0]              sat_sum;
  logic                            accept;

  hue_t    cutoff_q;
  stage1_t s1_q, s1_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign hues[0] = hue_corner0_i;
  assign hues[1] = hue_corner1_i;
  assign hues[2] = hue_corner2_i;
  assign hues[3] = hue_corner3_i;

  assign sat_sum = SatSumW'(sat_corner0_i) + SatSumW'(sat_corner1_i) +
                   SatSumW'(sat_corner2_i) + SatSumW'(sat_corner3_i);

  for (genvar c = 0; c < NumCorners; c++) begin : g_key
    assign keys[c] = (hues[c] > cutoff_q) ? '0 : hues[c];

    qcms_rank_lane u_rank (
      .keys_i     (keys),
      .lane_idx_i (idx_t'(c)),
      .rank_o     (ranks[c])
    );
  end

  for (genvar p = 0; p < NumPairs; p++) begin : g_pair
    qcms_gap_lane u_gap (
      .hue_a_i (hues[pair_hi(p)]),
      .hue_b_i (hues[pair_lo(p)]),
      .gap_o   (gaps[p])
    );
  end

  always_comb begin
    s1_d.valid   = accept;
    s1_d.sat_sum = sat_sum;
    for (int p = 0; p < NumPairs; p++) begin
      s1_d.gaps[p] = gaps[p];
    end
    for (int c = 0; c < NumCorners; c++) begin
      s1_d.ranks[c] = ranks[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= RedCutoffReset;
      s1_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cutoff_q <= cfg_data_i;
      end
      s1_q <= s1_d;
    end
  end

  qcms_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s1_i     (s1_q),
    .valid_o  (result_valid_o),
    .score_o  (marker_score_o),
    .red_o    (red_corner_o),
    .yellow_o (yellow_corner_o),
    .green_o  (green_corner_o),
    .blue_o   (blue_corner_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/qcms_gap_lane.sv
// Circular hue gap of one corner pair
`default_nettype none

module qcms_gap_lane
  import qcms_pkg::*;
(
  input  wire hue_t hue_a_i,
  input  wire hue_t hue_b_i,
  output gap_t      gap_o
);

  logic [HueW-1:0] hue_diff;
  logic [HueW:0]   wrapped;

  assign hue_diff = (hue_a_i >= hue_b_i) ? (hue_a_i - hue_b_i) : (hue_b_i - hue_a_i);
  assign wrapped  = FullTurn - {1'b0, hue_diff};
  assign gap_o    = (hue_diff > HalfTurn) ? gap_t'(wrapped[GapW-1:0]) : gap_t'(hue_diff);

endmodule

`default_nettype wire

FILE: hw/rtl/qcms_rank_lane.sv
// Sort position of one corner among the four ordering keys
`default_nettype none

module qcms_rank_lane
  import qcms_pkg::*;
(
  input  wire logic [NumCorners-1:0][HueW-1:0] keys_i,
  input  wire idx_t                            lane_idx_i,
  output idx_t                                 rank_o
);

  logic [NumCorners-1:0] ahead;

  always_comb begin
    for (int j = 0; j < NumCorners; j++) begin
      ahead[j] = (keys_i[j] < keys_i[lane_idx_i]) ||
                 ((keys_i[j] == keys_i[lane_idx_i]) && (idx_t'(j) < lane_idx_i));
    end
  end

  assign rank_o = idx_t'(ahead[0]) + idx_t'(ahead[1]) + idx_t'(ahead[2]) + idx_t'(ahead[3]);

endmodule

`default_nettype wire

FILE: hw/rtl/qcms_merge.sv
// Merge stage: minimum gap, colour slots, score product and scaled score
`default_nettype none

`include "quad_color_marker_scorer_assert.svh"

module qcms_merge
  import qcms_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire stage1_t s1_i,
  output logic         valid_o,
  output logic [ScoreW-1:0] score_o,
  output idx_t         red_o,
  output idx_t         yellow_o,
  output idx_t         green_o,
  output idx_t         blue_o
);

  gap_t g [NumPairs];
  gap_t m01, m23, m45, m03, min_gap;
  logic signed [ProdW:0] prod_full;
  idx_t slot [NumCorners];

  logic                     valid2_q;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  idx_t                     slot2_q [NumCorners];

  logic                     valid3_q;
  logic [ScoreW-1:0]        score_q, score_d;
  idx_t                     slot3_q [NumCorners];
  logic [QuotInW+12:0]      quot_full;

  always_comb begin
    for (int p = 0; p < NumPairs; p++) begin
      g[p] = $signed(s1_i.gaps[p]);
    end
  end

  assign m01     = (g[1] < g[0]) ? g[1] : g[0];
  assign m23     = (g[3] < g[2]) ? g[3] : g[2];
  assign m45     = (g[5] < g[4]) ? g[5] : g[4];
  assign m03     = (m23 < m01) ? m23 : m01;
  assign min_gap = (m45 < m03) ? m45 : m03;

  assign prod_full = min_gap * $signed({1'b0, s1_i.sat_sum});
  assign prod_d    = prod_full[ProdW-1:0];

  always_comb begin
    for (int s = 0; s < NumCorners; s++) begin
      slot[s] = '0;
      for (int c = 0; c < NumCorners; c++) begin
        if (s1_i.ranks[c] == idx_t'(s)) begin
          slot[s] = idx_t'(c);
        end
      end
    end
  end

  assign quot_full = prod_q[QuotInW-1:0] * RecipMul;

  always_comb begin
    if (prod_q <= 0) begin
      score_d = '0;
    end else if (prod_q >= $signed(SatLimit)) begin
      score_d = ScoreMax;
    end else begin
      score_d = quot_full[RecipShift +: ScoreW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid2_q <= s1_i.valid;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    score_q <= score_d;
    for (int s = 0; s < NumCorners; s++) begin
      slot2_q[s] <= slot[s];
      slot3_q[s] <= slot2_q[s];
    end
  end

  assign valid_o  = valid3_q;
  assign score_o  = score_q;
  assign red_o    = slot3_q[0];
  assign yellow_o = slot3_q[1];
  assign green_o  = slot3_q[2];
  assign blue_o   = slot3_q[3];

  `QCMS_ASSERT_NOW(a_min_gap_bound, clk_i, rst_ni, s1_i.valid, (min_gap <= $signed({1'b0, HalfTurn})))
  `QCMS_ASSERT_NEXT(a_nonpos_zero, clk_i, rst_ni, valid2_q && (prod_q <= 0), (score_o == '0))
  `QCMS_ASSERT_NEXT(a_big_saturates, clk_i, rst_ni, valid2_q && (prod_q >= $signed(SatLimit)), (score_o == ScoreMax))
  `QCMS_ASSERT_NOW(a_slots_distinct, clk_i, rst_ni, valid_o, (red_o != yellow_o) && (red_o != green_o) && (red_o != blue_o) && (yellow_o != green_o) && (yellow_o != blue_o) && (green_o != blue_o))

endmodule

`default_nettype wire
